### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks on the loader's ports.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk, switched off while rst is high
`define CHK_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("itfl port check failed");

// Check sampled on clk that also holds during reset
`define CHK_RESET(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("itfl reset check failed");

`endif

### design/itfl_pkg.sv
// ----------------------------------------------------------------------------
// itfl_pkg
// Types and constants of the I2C target flash loader.
// ----------------------------------------------------------------------------
package itfl_pkg;

  // Default sizes
  localparam int PAGE_BYTES_DEF  = 128;
  localparam int FLASH_BYTES_DEF = 28672;

  // Address pointer and remainder unit
  localparam int ADDR_W     = 16;
  localparam int MOD_STEP   = 4;                   // pointer bits per cycle
  localparam int MOD_CYCLES = ADDR_W / MOD_STEP;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  // Register window
  localparam logic [ADDR_W-1:0] WINDOW_BASE = 16'h8000;
  localparam logic [2:0] WINDOW_SIZE = 3'd6;
  localparam logic [2:0] WIN_SIG     = 3'd0;
  localparam logic [2:0] WIN_CTRL    = 3'd1;
  localparam logic [2:0] WIN_STATUS  = 3'd2;
  localparam logic [2:0] WIN_KEY     = 3'd3;
  localparam logic [2:0] WIN_PAGE_LO = 3'd4;
  localparam logic [2:0] WIN_PAGE_HI = 3'd5;

  localparam logic [7:0] SIGNATURE   = 8'h5A;
  localparam logic [7:0] KEY_VALUE   = 8'hAC;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Bus event kinds
  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_RECV   = 3'd1,
    KIND_REQ    = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_ERROR  = 3'd4,
    KIND_COMMIT = 3'd5
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_FREAD,
    ST_COPY,
    ST_COPY_END,
    ST_EMIT
  } state_t;

endpackage

### design/i2c_target_flash_loader_unit.sv
// ----------------------------------------------------------------------------
// i2c_target_flash_loader_unit
// Bootloader I2C target: address pointer, register window, page buffer, flash.
// ----------------------------------------------------------------------------
// One bus event per input transaction, one result per event. An event passes
// through accept, execute and result register; the second address byte adds
// the page offset remainder unit, a flash read adds the flash memory port,
// and a commit that programs flash copies the page, one page byte per cycle,
// through the page and flash memory ports. After reset a clearing pass over
// max(FLASH_BYTES, PAGE_BYTES) addresses (28672 by default) erases flash to
// 0xFF and zeroes the page buffer; no event is accepted until it ends. A new
// event is accepted while the previous result still waits on the output.
module i2c_target_flash_loader_unit #(
  parameter int PAGE_BYTES  = itfl_pkg::PAGE_BYTES_DEF,
  parameter int FLASH_BYTES = itfl_pkg::FLASH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_byte, [8] acknowledge,
                                 // [9] release_stop, [10] page_programmed,
                                 // [11] boot_application, [15:12] zero
);

  localparam int FA_W      = $clog2(FLASH_BYTES);
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int CLR_DEPTH = (FLASH_BYTES > PAGE_BYTES) ? FLASH_BYTES : PAGE_BYTES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int AW        = itfl_pkg::ADDR_W;

  localparam logic [OFF_W:0]   PAGE_REM   = (OFF_W+1)'(PAGE_BYTES);
  localparam logic [OFF_W-1:0] PAGE_LAST  = OFF_W'(PAGE_BYTES - 1);
  localparam logic [AW-1:0]    PAGE_W     = AW'(PAGE_BYTES);
  localparam logic [AW-1:0]    FLASH_W    = AW'(FLASH_BYTES);
  localparam logic [CLR_W:0]   CLR_FLASH  = (CLR_W+1)'(FLASH_BYTES);
  localparam logic [CLR_W:0]   CLR_PAGE   = (CLR_W+1)'(PAGE_BYTES);
  localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_DEPTH - 1);
  localparam logic [itfl_pkg::MOD_CNT_W-1:0] MOD_LAST =
    itfl_pkg::MOD_CNT_W'(itfl_pkg::MOD_CYCLES - 1);

  // Sequencer and captured transaction
  itfl_pkg::state_t state, state_next;
  logic [2:0] kind_q;
  logic [7:0] data_q;

  // Architectural state
  logic [AW-1:0]    ptr;
  logic [1:0]       seen;
  logic             ctrl_boot;
  logic             busy;
  logic [7:0]       key_reg;
  logic             updated;
  logic [AW-1:0]    page_base;
  logic [OFF_W-1:0] page_off;

  // Sweep counters
  logic [CLR_W-1:0] clr_idx;
  logic [OFF_W-1:0] copy_idx;
  logic [OFF_W-1:0] copy_off;
  logic             copy_wr;

  // Remainder unit
  logic [AW-1:0]                 mod_val;
  logic [OFF_W:0]                mod_rem;
  logic [OFF_W:0]                mod_rem_next;
  logic [itfl_pkg::MOD_CNT_W-1:0] mod_cnt;

  // Result and output register
  logic [7:0]  res_byte;
  logic        res_stop;
  logic        res_prog;
  logic        res_boot;
  logic        out_valid;
  logic [15:0] out_data;
  logic        out_load;

  // Memories
  logic [7:0] flash_mem [FLASH_BYTES];
  logic [7:0] page_mem  [PAGE_BYTES];
  logic             flash_we, flash_re;
  logic [FA_W-1:0]  flash_waddr, flash_raddr;
  logic [7:0]       flash_wdata, flash_rdata;
  logic             page_we, page_re;
  logic [OFF_W-1:0] page_waddr, page_raddr;
  logic [7:0]       page_wdata, page_rdata;

  // Decodes
  logic             addr_ready, in_window, in_flash, page_last;
  logic [2:0]       win_off;
  logic [7:0]       win_rdata;
  logic [AW-1:0]    ptr_inc;
  logic [OFF_W-1:0] off_inc;
  logic             recv_addr, recv_flash, req_flash, commit_copy;
  logic [AW-1:0]    copy_sum;
  logic             copy_in_range, clr_last, copy_last;

  assign addr_ready = (seen == 2'd2);
  assign in_window  = (ptr[AW-1:3] == itfl_pkg::WINDOW_BASE[AW-1:3]) &&
                      (ptr[2:0] < itfl_pkg::WINDOW_SIZE);
  assign in_flash   = (ptr < FLASH_W);
  assign win_off    = ptr[2:0];
  assign page_last  = (page_off == PAGE_LAST);
  assign ptr_inc    = ptr + 1'b1;
  // offset follows the pointer; a wrap of the pointer restarts it at zero
  assign off_inc    = (ptr == '1 || page_last) ? '0 : page_off + 1'b1;

  assign recv_addr   = (kind_q == itfl_pkg::KIND_RECV) && (seen == 2'd1);
  assign recv_flash  = (kind_q == itfl_pkg::KIND_RECV) && addr_ready && !in_window &&
                       in_flash && !busy;
  assign req_flash   = (kind_q == itfl_pkg::KIND_REQ) && addr_ready && !in_window &&
                       in_flash;
  assign commit_copy = (kind_q == itfl_pkg::KIND_COMMIT) && updated && busy &&
                       (key_reg == itfl_pkg::KEY_VALUE);

  assign copy_sum      = page_base + AW'(copy_off);
  assign copy_in_range = (copy_sum < FLASH_W);
  assign clr_last      = (clr_idx == CLR_LAST);
  assign copy_last     = (copy_idx == PAGE_LAST);

  // Register window read
  always_comb begin
    case (win_off)
      itfl_pkg::WIN_SIG:     win_rdata = itfl_pkg::SIGNATURE;
      itfl_pkg::WIN_CTRL:    win_rdata = {7'd0, ctrl_boot};
      itfl_pkg::WIN_STATUS:  win_rdata = {7'd0, busy};
      itfl_pkg::WIN_KEY:     win_rdata = key_reg;
      itfl_pkg::WIN_PAGE_LO: win_rdata = PAGE_W[7:0];
      itfl_pkg::WIN_PAGE_HI: win_rdata = PAGE_W[15:8];
      default:               win_rdata = 8'd0;
    endcase
  end

  // Remainder steps: shift in pointer bits, subtract page size
  always_comb begin
    mod_rem_next = mod_rem;
    for (int j = 0; j < itfl_pkg::MOD_STEP; j++) begin
      mod_rem_next = {mod_rem_next[OFF_W-1:0], mod_val[AW-1-j]};
      if (mod_rem_next >= PAGE_REM) begin
        mod_rem_next = mod_rem_next - PAGE_REM;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      itfl_pkg::ST_CLEAR: if (clr_last) state_next = itfl_pkg::ST_IDLE;
      itfl_pkg::ST_IDLE:  if (s_tvalid) state_next = itfl_pkg::ST_EXEC;
      itfl_pkg::ST_EXEC: begin
        if (recv_addr)        state_next = itfl_pkg::ST_MOD;
        else if (req_flash)   state_next = itfl_pkg::ST_FREAD;
        else if (commit_copy) state_next = itfl_pkg::ST_COPY;
        else                  state_next = itfl_pkg::ST_EMIT;
      end
      itfl_pkg::ST_MOD:      if (mod_cnt == MOD_LAST) state_next = itfl_pkg::ST_EMIT;
      itfl_pkg::ST_FREAD:    state_next = itfl_pkg::ST_EMIT;
      itfl_pkg::ST_COPY:     if (copy_last) state_next = itfl_pkg::ST_COPY_END;
      itfl_pkg::ST_COPY_END: state_next = itfl_pkg::ST_EMIT;
      itfl_pkg::ST_EMIT:     if (!out_valid || m_tready) state_next = itfl_pkg::ST_IDLE;
      default:               state_next = itfl_pkg::ST_CLEAR;
    endcase
  end

  // Handshake and memory port controls
  always_comb begin
    s_tready    = (state == itfl_pkg::ST_IDLE);
    out_load    = (state == itfl_pkg::ST_EMIT) && (!out_valid || m_tready);

    flash_we    = 1'b0;
    flash_waddr = clr_idx[FA_W-1:0];
    flash_wdata = itfl_pkg::ERASED_BYTE;
    if (state == itfl_pkg::ST_CLEAR) begin
      flash_we = ({1'b0, clr_idx} < CLR_FLASH);
    end else if (copy_wr) begin
      flash_we    = copy_in_range;
      flash_waddr = copy_sum[FA_W-1:0];
      flash_wdata = page_rdata;
    end
    flash_re    = (state == itfl_pkg::ST_EXEC) && req_flash;
    flash_raddr = ptr[FA_W-1:0];

    page_we    = 1'b0;
    page_waddr = clr_idx[OFF_W-1:0];
    page_wdata = 8'd0;
    if (state == itfl_pkg::ST_CLEAR) begin
      page_we = ({1'b0, clr_idx} < CLR_PAGE);
    end else if (state == itfl_pkg::ST_EXEC && recv_flash) begin
      page_we    = 1'b1;
      page_waddr = page_off;
      page_wdata = data_q;
    end
    page_re    = (state == itfl_pkg::ST_COPY);
    page_raddr = copy_idx;
  end

  // Flash memory
  always_ff @(posedge clk) begin
    if (flash_we) flash_mem[flash_waddr] <= flash_wdata;
    if (flash_re) flash_rdata <= flash_mem[flash_raddr];
  end

  // Page buffer memory
  always_ff @(posedge clk) begin
    if (page_we) page_mem[page_waddr] <= page_wdata;
    if (page_re) page_rdata <= page_mem[page_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= itfl_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // Clearing sweep and copy pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      copy_wr <= 1'b0;
    end else begin
      if (state == itfl_pkg::ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      copy_wr <= (state == itfl_pkg::ST_COPY);
    end
  end

  // Copy addresses
  always_ff @(posedge clk) begin
    if (state == itfl_pkg::ST_EXEC) copy_idx <= '0;
    else if (state == itfl_pkg::ST_COPY) copy_idx <= copy_idx + 1'b1;
    if (state == itfl_pkg::ST_COPY) copy_off <= copy_idx;
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind_q <= s_tuser;
      data_q <= s_tdata;
    end
  end

  // Event execution, remainder unit and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      seen      <= '0;
      ctrl_boot <= 1'b0;
      busy      <= 1'b0;
      key_reg   <= '0;
      updated   <= 1'b0;
      page_base <= '0;
      page_off  <= '0;
      mod_cnt   <= '0;
    end else begin
      unique case (state)
        itfl_pkg::ST_EXEC: begin
          // result of this event; a flash read fills the byte in ST_FREAD
          res_byte <= ((kind_q == itfl_pkg::KIND_REQ) && addr_ready && in_window) ?
                      win_rdata : 8'd0;
          res_stop <= (kind_q == itfl_pkg::KIND_ERROR);
          res_prog <= commit_copy;
          res_boot <= (kind_q == itfl_pkg::KIND_COMMIT) && updated && !busy &&
                      ctrl_boot;
          case (kind_q)
            itfl_pkg::KIND_START: seen <= 2'd0;
            itfl_pkg::KIND_RECV: begin
              if (!addr_ready) begin
                // big-endian pointer byte
                ptr     <= {ptr[7:0], data_q};
                seen    <= seen + 1'b1;
                mod_val <= {ptr[7:0], data_q};
                mod_rem <= '0;
                mod_cnt <= '0;
              end else if (in_window) begin
                if (win_off == itfl_pkg::WIN_CTRL)     ctrl_boot <= data_q[0];
                else if (win_off == itfl_pkg::WIN_KEY) key_reg   <= data_q;
                updated  <= 1'b1;
                ptr      <= ptr_inc;
                page_off <= off_inc;
              end else if (in_flash && !busy) begin
                // last byte of a page locks the buffer
                if (page_last) begin
                  page_base <= ptr - AW'(page_off);
                  busy      <= 1'b1;
                  updated   <= 1'b1;
                end
                ptr      <= ptr_inc;
                page_off <= off_inc;
              end
            end
            itfl_pkg::KIND_REQ: begin
              if (addr_ready && (in_window || in_flash)) begin
                ptr      <= ptr_inc;
                page_off <= off_inc;
              end
            end
            itfl_pkg::KIND_COMMIT: begin
              if (updated) begin
                updated <= 1'b0;
                if (busy) busy <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        itfl_pkg::ST_MOD: begin
          mod_rem <= mod_rem_next;
          mod_val <= mod_val << itfl_pkg::MOD_STEP;
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == MOD_LAST) page_off <= mod_rem_next[OFF_W-1:0];
        end
        itfl_pkg::ST_FREAD: res_byte <= flash_rdata;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= {4'd0, res_boot, res_prog, res_stop, 1'b1, res_byte};
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### design/itfl_checker.sv
// ----------------------------------------------------------------------------
// itfl_checker
// Port-level checks of the flash loader, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itfl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // reset starts the clearing pass: no input taken, no result shown
  `CHK_RESET(a_reset_quiet, rst |=> !s_tready && !m_tvalid)

  // one event at a time: ready drops after each accepted transaction
  `CHK_PROP(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready)

  // a stalled result holds
  `CHK_PROP(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

bind i2c_target_flash_loader_unit itfl_checker u_itfl_checker (.*);
